@@ sv/crc32sr_pkg.sv @@
// Package for the CRC-32 stream receiver: beat types, codes and constants.
// Used by every module of the block and by its checker; depends on nothing.

package crc32sr_pkg;

	localparam int unsigned PAGE_BYTES = 256;

	localparam int unsigned SIZE_W   = 23;
	localparam int unsigned SLOT_W   = 8;
	localparam int unsigned LEN_W    = 9;
	localparam int unsigned CRC_W    = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
	localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFFFFFF;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	localparam logic [1:0] ST_START_OK   = 2'd0;
	localparam logic [1:0] ST_START_BUSY = 2'd1;
	localparam logic [1:0] ST_BYTE_OK    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CRC  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR    = 2'd2;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [BYTE_W-1:0] byte_out;
		logic [SLOT_W-1:0] buffer_slot;
		logic              page_flush;
		logic [SIZE_W-1:0] page_address;
		logic [LEN_W-1:0]  page_length;
		logic [SIZE_W-1:0] received_count;
		logic              done_res;
		logic              crc_ok;
		logic [CRC_W-1:0]  final_crc;
	} out_item_t;

endpackage

@@ sv/crc32sr_crc_update.sv @@
// Byte-wide update of a reflected CRC-32, all eight bit steps done combinationally.
// Depends on crc32sr_pkg for the polynomial and widths.

module crc32sr_crc_update (
	input  logic [crc32sr_pkg::CRC_W-1:0]  crc,
	input  logic [crc32sr_pkg::BYTE_W-1:0] data,
	output logic [crc32sr_pkg::CRC_W-1:0]  crc_next
);

	logic [crc32sr_pkg::CRC_W-1:0] c;

	always_comb begin
		c = crc ^ {{(crc32sr_pkg::CRC_W - crc32sr_pkg::BYTE_W){1'b0}}, data};
		for (int k = 0; k < crc32sr_pkg::BYTE_W; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ crc32sr_pkg::CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule

@@ sv/crc32_stream_receiver.sv @@
// Top level of the CRC-32 stream receiver: handshakes, state and result register.
// Depends on crc32sr_pkg and crc32sr_crc_update.

// The item channel (item_valid, item_ready, item) carries one beat per command:
// a start command arms the block, a data command carries one payload byte.
// The result channel (result_valid, result_ready, result) returns at most one
// beat per item: start accepted, start rejected while busy, or byte accepted with
// its page slot, page flush request, running count and, on the last byte, the
// final CRC and its match flag. Data beats that arrive while idle give no result.
// The cfg port writes expected_size, expected_crc and write_start_address on any
// cycle with cfg_we high; it should only be used while no beat is in flight.
// An accepted item is held in an input register until the result register can
// take its result; result_valid is driven from the result register.
// One item is taken every cycle as long as the result side keeps up; the
// combinational CRC byte update allows this rate.
// When result_ready is low the result register holds its beat, the input
// register fills, and item_ready drops until the result is taken.
// Reset clears both registers' valid flags, returns the block to idle with the
// CRC at all ones and loads the configuration reset values.

module crc32_stream_receiver (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	output logic                                   item_ready,
	input  crc32sr_pkg::in_item_t                  item,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output crc32sr_pkg::out_item_t                 result,
	input  logic                                   cfg_we,
	input  logic [crc32sr_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [crc32sr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned SW = crc32sr_pkg::SIZE_W;
	localparam int unsigned LW = crc32sr_pkg::LEN_W;
	localparam int unsigned CW = crc32sr_pkg::CRC_W;
	localparam int unsigned PW = crc32sr_pkg::SLOT_W;

	logic [SW-1:0] exp_size_q;
	logic [CW-1:0] exp_crc_q;
	logic [SW-1:0] start_addr_q;

	logic          receiving_q;
	logic [CW-1:0] crc_q;
	logic [SW-1:0] count_q;
	logic [PW-1:0] fill_q;
	logic [SW-1:0] waddr_q;

	logic                  valid_s1;
	crc32sr_pkg::in_item_t item_s1;
	logic                   res_valid_q;
	crc32sr_pkg::out_item_t res_q;

	logic                   advance;
	logic                   fire;
	logic                   has_result;
	crc32sr_pkg::out_item_t res_d;
	logic [CW-1:0]          crc_next;
	logic [CW-1:0]          fin_crc;
	logic [LW-1:0]          fill;
	logic [SW-1:0]          count_next;
	logic                   done;
	logic                   flush;

	assign advance    = !res_valid_q || result_ready;
	assign item_ready = !valid_s1 || advance;
	assign fire       = valid_s1 && advance;

	crc32sr_crc_update u_crc (
		.crc      (crc_q),
		.data     (item_s1.data_byte),
		.crc_next (crc_next)
	);

	assign fill       = {1'b0, fill_q} + LW'(1);
	assign count_next = count_q + SW'(1);
	assign done       = count_next == exp_size_q;
	assign flush      = (fill >= LW'(crc32sr_pkg::PAGE_BYTES)) || done;
	assign fin_crc    = crc_next ^ crc32sr_pkg::CRC_ONES;

	always_comb begin
		res_d      = '0;
		has_result = 1'b1;
		if (item_s1.command == crc32sr_pkg::CMD_START) begin
			res_d.status = receiving_q ? crc32sr_pkg::ST_START_BUSY
			                           : crc32sr_pkg::ST_START_OK;
		end else if (!receiving_q) begin
			has_result = 1'b0;
		end else begin
			res_d.status         = crc32sr_pkg::ST_BYTE_OK;
			res_d.byte_out       = item_s1.data_byte;
			res_d.buffer_slot    = fill_q;
			res_d.received_count = count_next;
			if (flush) begin
				res_d.page_flush   = 1'b1;
				res_d.page_address = waddr_q;
				res_d.page_length  = fill;
			end
			if (done) begin
				res_d.done_res  = 1'b1;
				res_d.crc_ok    = fin_crc == exp_crc_q;
				res_d.final_crc = fin_crc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_size_q   <= SW'(1);
			exp_crc_q    <= '0;
			start_addr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crc32sr_pkg::CFG_EXPECTED_SIZE: exp_size_q   <= cfg_data[SW-1:0];
				crc32sr_pkg::CFG_EXPECTED_CRC:  exp_crc_q    <= cfg_data[CW-1:0];
				crc32sr_pkg::CFG_START_ADDR:    start_addr_q <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			crc_q       <= crc32sr_pkg::CRC_ONES;
			count_q     <= '0;
			fill_q      <= '0;
			waddr_q     <= '0;
		end else if (fire) begin
			if (item_s1.command == crc32sr_pkg::CMD_START) begin
				if (!receiving_q) begin
					receiving_q <= 1'b1;
					crc_q       <= crc32sr_pkg::CRC_ONES;
					count_q     <= '0;
					fill_q      <= '0;
					waddr_q     <= start_addr_q;
				end
			end else if (receiving_q) begin
				crc_q   <= crc_next;
				count_q <= count_next;
				if (flush) begin
					fill_q  <= '0;
					waddr_q <= waddr_q + SW'(fill);
				end else begin
					fill_q <= fill[PW-1:0];
				end
				if (done) begin
					receiving_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1 && has_result;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire && has_result) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ sv/crc32sr_checker.sv @@
// Port-level checker for the CRC-32 stream receiver, bound to the top level.
// Depends on crc32sr_pkg for the result type and status codes.

module crc32sr_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_ready,
	input crc32sr_pkg::out_item_t result
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("Result beat changed or dropped while stalled.");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == crc32sr_pkg::ST_START_OK ||
		result.status == crc32sr_pkg::ST_START_BUSY)
		|-> result.received_count == '0 && !result.page_flush && !result.done_res
		&& result.final_crc == '0 && result.byte_out == '0)
		else $error("Start result carries nonzero byte fields.");

	a_flush_length: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.page_flush == (result.page_length != '0))
		else $error("Page length does not agree with page flush.");

	a_done_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> result.page_flush &&
		result.status == crc32sr_pkg::ST_BYTE_OK)
		else $error("Final byte did not flush its page.");

endmodule

bind crc32_stream_receiver crc32sr_checker u_crc32sr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

@@ tb/tb_crc32_stream_receiver.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for crc32_stream_receiver: directed and random payloads,
// with a page and CRC tracker that predicts every result beat. Depends on crc32sr_pkg.

module tb_crc32_stream_receiver;

	import crc32sr_pkg::*;

	class crc_page_tracker;

		logic [SIZE_W-1:0] size_reg;
		logic [CRC_W-1:0]  crc_reg;
		logic [SIZE_W-1:0] base_reg;
		logic              receiving;
		logic [CRC_W-1:0]  crc_acc;
		logic [SIZE_W-1:0] count;
		logic [LEN_W-1:0]  fill;
		logic [SIZE_W-1:0] wr_addr;
		out_item_t         pending_beats [$];
		int                mismatches;

		function new();
			size_reg   = SIZE_W'(1);
			crc_reg    = '0;
			base_reg   = '0;
			receiving  = 1'b0;
			crc_acc    = CRC_ONES;
			count      = '0;
			fill       = '0;
			wr_addr    = '0;
			mismatches = 0;
		endfunction

		static function logic [CRC_W-1:0] crc_byte_step(logic [CRC_W-1:0] c, logic [7:0] b);
			logic [CRC_W-1:0] acc;
			acc = c ^ {24'd0, b};
			for (int k = 0; k < 8; k++) begin
				if (acc[0]) begin
					acc = (acc >> 1) ^ CRC_POLY;
				end else begin
					acc = acc >> 1;
				end
			end
			return acc;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_EXPECTED_SIZE: size_reg = val[SIZE_W-1:0];
				CFG_EXPECTED_CRC:  crc_reg = val;
				CFG_START_ADDR:    base_reg = val[SIZE_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_item(in_item_t beat);
			out_item_t        r;
			logic [LEN_W-1:0] next_fill;
			logic             done;
			r = '0;
			if (beat.command == CMD_START) begin
				if (receiving) begin
					r.status = ST_START_BUSY;
				end else begin
					receiving = 1'b1;
					crc_acc   = CRC_ONES;
					count     = '0;
					fill      = '0;
					wr_addr   = base_reg;
					r.status  = ST_START_OK;
				end
				pending_beats.push_back(r);
			end else if (receiving) begin
				r.status         = ST_BYTE_OK;
				r.byte_out       = beat.data_byte;
				r.buffer_slot    = fill[SLOT_W-1:0];
				crc_acc          = crc_byte_step(crc_acc, beat.data_byte);
				count            = count + 1'b1;
				r.received_count = count;
				next_fill        = fill + 1'b1;
				done             = (count == size_reg);
				if (next_fill >= PAGE_BYTES || done) begin
					r.page_flush   = 1'b1;
					r.page_address = wr_addr;
					r.page_length  = next_fill;
					wr_addr        = wr_addr + SIZE_W'(next_fill);
					fill           = '0;
				end else begin
					fill = next_fill;
				end
				if (done) begin
					receiving   = 1'b0;
					r.done_res  = 1'b1;
					r.final_crc = ~crc_acc;
					r.crc_ok    = (~crc_acc == crc_reg);
				end
				pending_beats.push_back(r);
			end
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task field_cmp(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) begin
				report($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
			end
		endtask

		task match_beat(out_item_t got);
			out_item_t want;
			if (pending_beats.size() == 0) begin
				report("result beat arrived with nothing expected");
			end else begin
				want = pending_beats.pop_front();
				field_cmp("status", 32'(got.status), 32'(want.status));
				field_cmp("byte_out", 32'(got.byte_out), 32'(want.byte_out));
				field_cmp("buffer_slot", 32'(got.buffer_slot), 32'(want.buffer_slot));
				field_cmp("page_flush", 32'(got.page_flush), 32'(want.page_flush));
				field_cmp("page_address", 32'(got.page_address), 32'(want.page_address));
				field_cmp("page_length", 32'(got.page_length), 32'(want.page_length));
				field_cmp("received_count", 32'(got.received_count),
					32'(want.received_count));
				field_cmp("done_res", 32'(got.done_res), 32'(want.done_res));
				field_cmp("crc_ok", 32'(got.crc_ok), 32'(want.crc_ok));
				field_cmp("final_crc", got.final_crc, want.final_crc);
			end
		endtask

	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	in_item_t              item = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	out_item_t             result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	crc_page_tracker tracker;
	bit              idle_on = 1'b0;
	int              ready_hold = 0;
	int unsigned     beats_sent = 0;

	crc32_stream_receiver i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold--;
			result_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			ready_hold = $urandom_range(0, 4);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				tracker.match_beat(result);
			end
			if (item_valid && item_ready) begin
				tracker.take_item(item);
			end
		end
	end

	function automatic logic [CRC_W-1:0] payload_crc(input logic [7:0] bytes [$]);
		logic [CRC_W-1:0] acc;
		acc = CRC_ONES;
		foreach (bytes[i]) begin
			acc = crc_page_tracker::crc_byte_step(acc, bytes[i]);
		end
		return ~acc;
	endfunction

	task automatic send(input logic cmd, input logic [7:0] b);
		in_item_t beat;
		beat.command   = cmd;
		beat.data_byte = b;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic settle();
		item_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending_beats.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [SIZE_W-1:0] size, input logic [CRC_W-1:0] crc,
			input logic [SIZE_W-1:0] base);
		settle();
		cfg_we   <= 1'b1;
		cfg_addr <= CFG_EXPECTED_SIZE;
		cfg_data <= CFG_DATA_W'(size);
		@(posedge clk);
		cfg_addr <= CFG_EXPECTED_CRC;
		cfg_data <= crc;
		@(posedge clk);
		cfg_addr <= CFG_START_ADDR;
		cfg_data <= CFG_DATA_W'(base);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_reg(CFG_EXPECTED_SIZE, CFG_DATA_W'(size));
		tracker.set_reg(CFG_EXPECTED_CRC, crc);
		tracker.set_reg(CFG_START_ADDR, CFG_DATA_W'(base));
	endtask

	task automatic run_transfer(input int unsigned size, input logic [SIZE_W-1:0] base,
			input bit match);
		logic [7:0]       payload [$];
		logic [CRC_W-1:0] target;
		int unsigned      length;
		int unsigned      sent;
		for (int i = 0; i < size; i++) begin
			payload.push_back(8'($urandom_range(0, 255)));
		end
		target = match ? payload_crc(payload) : $urandom;
		configure(SIZE_W'(size), target, base);
		if ($urandom_range(0, 3) == 0) begin
			send(CMD_DATA, 8'($urandom_range(0, 255)));
		end
		send(CMD_START, 8'($urandom_range(0, 255)));
		beats_sent++;
		length = size;
		sent   = 0;
		while (sent < length) begin
			if ($urandom_range(0, 19) == 0) begin
				send(CMD_START, 8'($urandom_range(0, 255)));
				beats_sent++;
			end
			if (sent == length / 2 && $urandom_range(0, 4) == 0) begin
				settle();
			end
			if (sent == length / 2 && $urandom_range(0, 7) == 0) begin
				// The size is changed mid transfer, so the end moves.
				length = sent + $urandom_range(1, 8);
				configure(SIZE_W'(length), target, base);
			end
			send(CMD_DATA, sent < payload.size() ? payload[sent]
				: 8'($urandom_range(0, 255)));
			sent++;
			beats_sent++;
		end
	endtask

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		logic [7:0]        fixed [$];
		int unsigned       size;
		logic [SIZE_W-1:0] base;
		int unsigned       pick;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_on = 1'b1;

		send(CMD_DATA, 8'hA5);
		send(CMD_START, 8'h00);
		send(CMD_DATA, 8'h00);

		fixed = '{8'hFF, 8'h80, 8'h01};
		configure(23'd3, payload_crc(fixed), 23'h7FFFFF);
		send(CMD_START, 8'hFF);
		send(CMD_START, 8'h5A);
		foreach (fixed[i]) begin
			send(CMD_DATA, fixed[i]);
		end
		send(CMD_DATA, 8'h55);

		// The size is moved below the count, and to zero, while a transfer runs.
		configure(23'h7FFFFF, 32'hFFFFFFFF, 23'd0);
		send(CMD_START, 8'h00);
		repeat (3) send(CMD_DATA, 8'($urandom_range(0, 255)));
		configure(23'd2, 32'd0, 23'd0);
		repeat (2) send(CMD_DATA, 8'($urandom_range(0, 255)));
		configure(23'd0, 32'd0, 23'd0);
		send(CMD_DATA, 8'($urandom_range(0, 255)));
		configure(23'd8, 32'hFFFFFFFF, 23'h400000);
		repeat (2) send(CMD_DATA, 8'($urandom_range(0, 255)));

		beats_sent = 0;
		run_transfer(260, 23'h7FFFC0, 1'b1);
		while (beats_sent < 400) begin
			idle_on = (beats_sent < 340) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				size = $urandom_range(1, 16);
			end else if (pick < 9) begin
				size = $urandom_range(17, 64);
			end else begin
				size = $urandom_range(240, 300);
			end
			if (beats_sent + size > 420) begin
				size = 420 - beats_sent;
			end
			if ($urandom_range(0, 3) == 0) begin
				base = 23'h7FFFFF - SIZE_W'($urandom_range(0, 300));
			end else begin
				base = SIZE_W'($urandom_range(0, 23'h7FFFFF));
			end
			run_transfer(size, base, 1'($urandom_range(0, 1)));
		end

		idle_on = 1'b0;
		settle();
		if (tracker.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ crc32_stream_receiver.f @@
sv/crc32sr_pkg.sv
sv/crc32sr_crc_update.sv
sv/crc32_stream_receiver.sv
sv/crc32sr_checker.sv
tb/tb_crc32_stream_receiver.sv
